>>> sv/hrf_pkg.sv
// Shared types, codes and constants of the HTTP request framer.
package hrf_pkg;

  // Width of the internal Content-Length accumulator and body counter.
  localparam int unsigned LengthWidth = 32;
  // Depth of the queue between front and back; a power of two.
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = $clog2(FifoDepth);

  localparam logic [1:0] OpData    = 2'd0;
  localparam logic [1:0] OpClose   = 2'd1;
  localparam logic [1:0] OpLinkErr = 2'd2;
  localparam logic [1:0] OpRestart = 2'd3;

  localparam logic [2:0] KindMethod  = 3'd0;
  localparam logic [2:0] KindUri     = 3'd1;
  localparam logic [2:0] KindVersion = 3'd2;
  localparam logic [2:0] KindKey     = 3'd3;
  localparam logic [2:0] KindValue   = 3'd4;
  localparam logic [2:0] KindBody    = 3'd5;
  localparam logic [2:0] KindNone    = 3'd6;

  localparam logic [2:0] StatusHeader = 3'd0;
  localparam logic [2:0] StatusBody   = 3'd1;
  localparam logic [2:0] StatusDone   = 3'd2;
  localparam logic [2:0] StatusClosed = 3'd3;
  localparam logic [2:0] StatusError  = 3'd4;

  localparam logic [3:0] KeyLen = 4'd14;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic [2:0]  status;
    logic        request_done;
    logic [31:0] body_length;
  } out_beat_t;

  // One received item plus the byte classes the parser needs.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_digit;
    logic       is_ws;
    logic [3:0] digit;
  } class_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Characters of the header name "Content-Length", in order.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/http_request_framer_unit.sv
// Top level of the HTTP request framer: front end, beat queue and parser back end.
//
// Usage: the input channel (in_valid_i / in_ready_o / in_beat_i) carries one beat per
// received request byte, or a connection-closed, link-error or restart event. The
// output channel (out_valid_o / out_ready_i / out_beat_o) returns exactly one beat
// per input beat, in order, tagging the byte as method, URI, version, header key,
// header value, body or delimiter, together with the parser status, a request-done
// flag and the parsed Content-Length value.
// An accepted beat is written into the four-entry queue, and the parser registers its
// result in the output register when it pops that beat from the queue.
// Throughput is one beat per cycle while the receiver does not stall; the parser updates
// its whole state for each byte it pops, so nothing but the output handshake limits it.
// When the receiver stalls, the result stays in the output register and the queue
// absorbs up to four further beats; in_ready_o falls only once the queue is full.
// Reset clears the parser to the start of a new request (method field, no length
// seen), empties the queue and drops any pending result. A restart beat does the
// same to the parser state but still yields its own output beat.
module http_request_framer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hrf_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hrf_pkg::out_beat_t out_beat_o
);
  import hrf_pkg::*;

  fifo_stat_t fifo_stat;
  class_t     push_data;
  class_t     pop_data;
  logic       push;
  logic       pop;

  // The front end classifies each byte as it is accepted.
  hrf_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue decouples acceptance from the parser and output stall.
  hrf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  // The back end runs the request parser and holds the result register.
  hrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .beat_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // The queue can never report empty and full together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.empty && fifo_stat.full))
    else $error("queue reports empty and full together");

  // A completed request always carries the done status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.request_done |-> out_beat_o.status == StatusDone)
    else $error("request done without done status");

  // Body bytes only appear while in the body or on the final body byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.byte_kind == KindBody |->
      out_beat_o.status == StatusBody || out_beat_o.status == StatusDone)
    else $error("body byte outside the body");

  // The parser only pops when the queue holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

endmodule

>>> sv/hrf_front.sv
// Front end: accepts input beats and classifies each received byte.
module hrf_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hrf_pkg::in_beat_t  in_beat_i,
  input  hrf_pkg::fifo_stat_t fifo_stat_i,
  output logic               push_o,
  output hrf_pkg::class_t    push_data_o
);
  import hrf_pkg::*;

  logic [7:0] c;

  assign c          = in_beat_i.data_byte;
  assign in_ready_o = !fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  always_comb begin
    push_data_o.operation = in_beat_i.operation;
    push_data_o.data_byte = c;
    push_data_o.is_space  = (c == 8'h20);
    push_data_o.is_cr     = (c == 8'h0D);
    push_data_o.is_lf     = (c == 8'h0A);
    push_data_o.is_colon  = (c == 8'h3A);
    push_data_o.is_digit  = (c >= 8'h30) && (c <= 8'h39);
    push_data_o.is_ws     = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    push_data_o.digit     = 4'(c - 8'h30);
  end

endmodule

>>> sv/hrf_fifo.sv
// Small queue of classified beats between the front and back ends.
module hrf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hrf_pkg::class_t     push_data_i,
  input  logic                pop_i,
  output hrf_pkg::class_t     pop_data_o,
  output hrf_pkg::fifo_stat_t stat_o
);
  import hrf_pkg::*;

  class_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]     count_q, count_d;
  logic                  do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (FifoPtrW+1)'(FifoDepth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/hrf_back.sv
// Back end: request parser state machine and registered result stage.
module hrf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrf_pkg::fifo_stat_t fifo_stat_i,
  input  hrf_pkg::class_t     beat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrf_pkg::out_beat_t  out_beat_o
);
  import hrf_pkg::*;

  localparam logic [3:0] StMethod  = 4'd0;
  localparam logic [3:0] StUri     = 4'd1;
  localparam logic [3:0] StVersion = 4'd2;
  localparam logic [3:0] StReqLf   = 4'd3;
  localparam logic [3:0] StLine    = 4'd4;
  localparam logic [3:0] StLineLf  = 4'd5;
  localparam logic [3:0] StBlankLf = 4'd6;
  localparam logic [3:0] StBody    = 4'd7;
  localparam logic [3:0] StDone    = 4'd8;
  localparam logic [3:0] StClosed  = 4'd9;
  localparam logic [3:0] StError   = 4'd10;

  localparam logic [1:0] PhKey   = 2'd0;
  localparam logic [1:0] PhDrop  = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;

  localparam logic [1:0] DgLead  = 2'd0;
  localparam logic [1:0] DgDigit = 2'd1;
  localparam logic [1:0] DgAfter = 2'd2;

  logic [3:0]             st_q, st_d;
  logic [3:0]             kmi_q, kmi_d;
  logic                   ksm_q, ksm_d;
  logic [1:0]             lp_q, lp_d;
  logic                   le_q, le_d;
  logic                   ls_q, ls_d;
  logic [1:0]             dp_q, dp_d;
  logic [LengthWidth-1:0] lv_q, lv_d;
  logic [LengthWidth-1:0] br_q, br_d;
  logic                   out_valid_q;
  out_beat_t              out_q, out_d;

  logic [LengthWidth+3:0] lv_ext, lv_next;
  logic                   lv_ovf;
  logic [2:0]             kind;
  logic                   done;

  assign pop_o       = !fifo_stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Ten times the value plus the digit, as shifts; overflow shows in the top bits.
  assign lv_ext  = (LengthWidth+4)'(lv_q);
  assign lv_next = (lv_ext << 3) + (lv_ext << 1) + (LengthWidth+4)'(beat_i.digit);
  assign lv_ovf  = |lv_next[LengthWidth+3:LengthWidth];

  function automatic logic [2:0] status_of(input logic [3:0] s);
    logic [2:0] r;
    priority if (s == StBody) begin
      r = StatusBody;
    end else if (s == StDone) begin
      r = StatusDone;
    end else if (s == StClosed) begin
      r = StatusClosed;
    end else if (s == StError) begin
      r = StatusError;
    end else begin
      r = StatusHeader;
    end
    return r;
  endfunction

  always_comb begin
    st_d  = st_q;
    kmi_d = kmi_q;
    ksm_d = ksm_q;
    lp_d  = lp_q;
    le_d  = le_q;
    ls_d  = ls_q;
    dp_d  = dp_q;
    lv_d  = lv_q;
    br_d  = br_q;
    kind  = KindNone;
    done  = 1'b0;

    unique case (beat_i.operation)
      OpData: begin
        unique case (st_q)
          StMethod: begin
            if (beat_i.is_space) st_d = StUri;
            else kind = KindMethod;
          end
          StUri: begin
            if (beat_i.is_space) st_d = StVersion;
            else kind = KindUri;
          end
          StVersion: begin
            if (beat_i.is_cr) st_d = StReqLf;
            else kind = KindVersion;
          end
          StReqLf, StLineLf: begin
            if (beat_i.is_lf) begin
              st_d  = StLine;
              kmi_d = '0;
              ksm_d = 1'b1;
              lp_d  = PhKey;
              le_d  = 1'b1;
            end else begin
              st_d = StError;
            end
          end
          StLine: begin
            if (beat_i.is_cr) begin
              if (le_q) begin
                st_d = StBlankLf;
              end else if (lp_q != PhValue || (ksm_q && dp_q == DgLead)) begin
                st_d = StError;
              end else begin
                st_d = StLineLf;
              end
            end else begin
              le_d = 1'b0;
              if (lp_q == PhKey) begin
                if (beat_i.is_colon) begin
                  lp_d = PhDrop;
                  if (ksm_q && kmi_q == KeyLen && !ls_q) begin
                    ls_d = 1'b1;
                    dp_d = DgLead;
                    lv_d = '0;
                  end else begin
                    ksm_d = 1'b0;
                  end
                end else begin
                  kind = KindKey;
                  if (ksm_q && kmi_q < KeyLen && beat_i.data_byte == key_char(kmi_q)) begin
                    kmi_d = kmi_q + 1'b1;
                  end else begin
                    ksm_d = 1'b0;
                  end
                end
              end else if (lp_q == PhDrop) begin
                lp_d = PhValue;
              end else begin
                kind = KindValue;
                if (ksm_q) begin
                  if (dp_q == DgLead) begin
                    if (beat_i.is_digit) begin
                      lv_d = LengthWidth'(beat_i.digit);
                      dp_d = DgDigit;
                    end else if (!beat_i.is_ws) begin
                      st_d = StError;
                    end
                  end else if (dp_q == DgDigit) begin
                    if (!beat_i.is_digit) begin
                      dp_d = DgAfter;
                    end else if (lv_ovf) begin
                      st_d = StError;
                    end else begin
                      lv_d = lv_next[LengthWidth-1:0];
                    end
                  end
                end
              end
            end
          end
          StBlankLf: begin
            if (!beat_i.is_lf) begin
              st_d = StError;
            end else if (ls_q && lv_q != '0) begin
              br_d = lv_q;
              st_d = StBody;
            end else begin
              st_d = StDone;
              done = 1'b1;
            end
          end
          StBody: begin
            kind = KindBody;
            br_d = br_q - 1'b1;
            if (br_q == LengthWidth'(1)) begin
              st_d = StDone;
              done = 1'b1;
            end
          end
          default: begin
            kind = KindNone;
          end
        endcase
      end
      OpClose: begin
        if (st_q != StError) st_d = StClosed;
      end
      OpLinkErr: begin
        st_d = StError;
      end
      OpRestart: begin
        st_d  = StMethod;
        kmi_d = '0;
        ksm_d = 1'b1;
        lp_d  = PhKey;
        le_d  = 1'b1;
        ls_d  = 1'b0;
        dp_d  = DgLead;
        lv_d  = '0;
        br_d  = '0;
      end
      default: begin
        st_d = st_q;
      end
    endcase

    out_d.out_byte     = (beat_i.operation == OpData) ? beat_i.data_byte : 8'h00;
    out_d.byte_kind    = kind;
    out_d.status       = status_of(st_d);
    out_d.request_done = done;
    out_d.body_length  = 32'(lv_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StMethod;
      kmi_q       <= '0;
      ksm_q       <= 1'b1;
      lp_q        <= PhKey;
      le_q        <= 1'b1;
      ls_q        <= 1'b0;
      dp_q        <= DgLead;
      lv_q        <= '0;
      br_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        st_q  <= st_d;
        kmi_q <= kmi_d;
        ksm_q <= ksm_d;
        lp_q  <= lp_d;
        le_q  <= le_d;
        ls_q  <= ls_d;
        dp_q  <= dp_d;
        lv_q  <= lv_d;
        br_q  <= br_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule
